// ===== rtl/fk_pkg.sv =====
`timescale 1ns / 1ps
package fk_pkg;

   localparam int ANGLE_W = 16;
   localparam int LEN_W = 16;
   localparam int ROT_OUT_W = 16;
   localparam int POS_OUT_W = 23;
   // Internal position width; leaves headroom for the rotations about offset axes.
   localparam int POS_W = 28;
   localparam int CSR_INDEX_W = 3;

   localparam logic [31:0] PI_QUARTER_Q32 = 32'hC90F_DAA2;
   localparam logic [32:0] Q32_ONE = 33'h1_0000_0000;

   localparam longint POS_SAT_MAX = 64'sd4194303;
   localparam longint POS_SAT_MIN = -64'sd4194304;

   // Horner divisors, innermost term first.
   localparam int SIN_DIV [5] = '{110, 72, 42, 20, 6};
   localparam int COS_DIV [6] = '{132, 90, 56, 30, 12, 2};

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BASE_TO_SHOULDER = 3'd0,
      CSR_UPPER_ARM        = 3'd1,
      CSR_FOREARM_HEIGHT   = 3'd2,
      CSR_BASE_HEIGHT      = 3'd3,
      CSR_WRIST_OFFSET     = 3'd4,
      CSR_TOOL_OFFSET      = 3'd5
   } csr_index_type;

endpackage

// ===== rtl/fk_req_if.sv =====
`timescale 1ns / 1ps
interface fk_req_if;
   import fk_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [ANGLE_W-1:0] angle_one;
   logic signed [ANGLE_W-1:0] angle_two;
   logic signed [ANGLE_W-1:0] angle_three;
   logic signed [ANGLE_W-1:0] angle_four;
   logic signed [ANGLE_W-1:0] angle_five;
   logic signed [ANGLE_W-1:0] angle_six;

   modport source (output valid, angle_one, angle_two, angle_three, angle_four, angle_five,
                   angle_six, input ready);
   modport sink (input valid, angle_one, angle_two, angle_three, angle_four, angle_five,
                 angle_six, output ready);
endinterface

// ===== rtl/fk_rsp_if.sv =====
`timescale 1ns / 1ps
interface fk_rsp_if;
   import fk_pkg::*;
   logic                        valid;
   logic                        ready;
   logic signed [ROT_OUT_W-1:0] rot_xx;
   logic signed [ROT_OUT_W-1:0] rot_xy;
   logic signed [ROT_OUT_W-1:0] rot_xz;
   logic signed [ROT_OUT_W-1:0] rot_yx;
   logic signed [ROT_OUT_W-1:0] rot_yy;
   logic signed [ROT_OUT_W-1:0] rot_yz;
   logic signed [ROT_OUT_W-1:0] rot_zx;
   logic signed [ROT_OUT_W-1:0] rot_zy;
   logic signed [ROT_OUT_W-1:0] rot_zz;
   logic signed [POS_OUT_W-1:0] pos_x;
   logic signed [POS_OUT_W-1:0] pos_y;
   logic signed [POS_OUT_W-1:0] pos_z;

   modport source (output valid, rot_xx, rot_xy, rot_xz, rot_yx, rot_yy, rot_yz, rot_zx,
                   rot_zy, rot_zz, pos_x, pos_y, pos_z, input ready);
   modport sink (input valid, rot_xx, rot_xy, rot_xz, rot_yx, rot_yy, rot_yz, rot_zx,
                 rot_zy, rot_zz, pos_x, pos_y, pos_z, output ready);
endinterface

// ===== rtl/fk_csr_if.sv =====
`timescale 1ns / 1ps
interface fk_csr_if;
   import fk_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [LEN_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/fk_horner_cell.sv =====
`timescale 1ns / 1ps
module fk_horner_cell #(
   parameter int K = 6,
   parameter int SIDE_W = 32
) (
   input  logic              clock,
   input  logic              en,
   input  logic [31:0]       x2_i,
   input  logic [32:0]       t_i,
   input  logic [SIDE_W-1:0] side_i,
   output logic [31:0]       x2_o,
   output logic [32:0]       t_o,
   output logic [SIDE_W-1:0] side_o
);
   import fk_pkg::*;

   // Quotient by K through a reciprocal that never overestimates; one fix-up step.
   localparam int S = 32 + $clog2(K);
   localparam logic [32:0] RECIP = 33'((64'd1 << S) / K);

   logic [31:0]       p_a_ff, p_a_in;
   logic [31:0]       x2_a_ff, x2_b_ff, x2_c_ff;
   logic [SIDE_W-1:0] side_a_ff, side_b_ff, side_c_ff;
   logic [31:0]       p_b_ff;
   logic [31:0]       q_b_ff, q_b_in;
   logic [32:0]       t_c_ff, t_c_in;
   logic [64:0]       prod_a;
   logic [64:0]       prod_b;
   logic [31:0]       rem;
   logic [31:0]       q_fix;

   always_comb begin
      prod_a = 65'(x2_i) * 65'(t_i);
      p_a_in = prod_a[63:32];
      prod_b = 65'(p_a_ff) * 65'(RECIP);
      q_b_in = 32'(prod_b >> S);
      rem = p_b_ff - q_b_ff * 32'(K);
      q_fix = (rem >= 32'(K)) ? q_b_ff + 32'd1 : q_b_ff;
      t_c_in = Q32_ONE - 33'(q_fix);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_a_ff <= p_a_in;
         x2_a_ff <= x2_i;
         side_a_ff <= side_i;
         p_b_ff <= p_a_ff;
         q_b_ff <= q_b_in;
         x2_b_ff <= x2_a_ff;
         side_b_ff <= side_a_ff;
         t_c_ff <= t_c_in;
         x2_c_ff <= x2_b_ff;
         side_c_ff <= side_b_ff;
      end
   end

   assign x2_o = x2_c_ff;
   assign t_o = t_c_ff;
   assign side_o = side_c_ff;

endmodule

// ===== rtl/fk_sincos.sv =====
`timescale 1ns / 1ps
module fk_sincos #(
   parameter int ANGLE_BITS = 16,
   parameter int ROT_FRAC_BITS = 14
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic [fk_pkg::ANGLE_W-1:0]     angle_i,
   output logic signed [ROT_FRAC_BITS+1:0] sin_o,
   output logic signed [ROT_FRAC_BITS+1:0] cos_o
);
   import fk_pkg::*;

   localparam int A = ANGLE_BITS;
   localparam int F = ROT_FRAC_BITS;
   localparam int W = F + 2;
   localparam int RW = A - 3;
   localparam logic [RW:0] SPAN = {1'b1, {RW{1'b0}}};
   localparam logic [33:0] HALF_Q = 34'd1 << (31 - F);

   logic signed [31:0] ext;
   logic [A-1:0]       ang;
   logic [2:0]         oct_in;
   logic [RW:0]        r_in;
   logic [RW+32:0]     xp;
   logic [31:0]        x_ff, x_in;
   logic [2:0]         oct_ff;
   logic [63:0]        sq;
   logic [31:0]        x2_ff, x_2_ff;
   logic [2:0]         oct_2_ff;

   // The top three angle bits select the octant; odd octants mirror the remainder.
   always_comb begin
      ext = 32'($signed(angle_i));
      ang = ext[A-1:0];
      oct_in = ang[A-1:A-3];
      r_in = {1'b0, ang[RW-1:0]};
      if (oct_in[0]) begin
         r_in = SPAN - r_in;
      end
      xp = (RW+33)'(r_in) * (RW+33)'(PI_QUARTER_Q32);
      x_in = 32'(xp >> RW);
      sq = 64'(x_ff) * 64'(x_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         oct_ff <= oct_in;
         x2_ff <= sq[63:32];
         x_2_ff <= x_ff;
         oct_2_ff <= oct_ff;
      end
   end

   logic [31:0] sin_x2 [6];
   logic [32:0] sin_t [6];
   logic [31:0] sin_x [6];
   logic [31:0] cos_x2 [7];
   logic [32:0] cos_t [7];
   logic [2:0]  cos_oct [7];

   assign sin_x2[0] = x2_ff;
   assign sin_t[0] = Q32_ONE;
   assign sin_x[0] = x_2_ff;
   assign cos_x2[0] = x2_ff;
   assign cos_t[0] = Q32_ONE;
   assign cos_oct[0] = oct_2_ff;

   for (genvar i = 0; i < 5; i++) begin : g_sin
      fk_horner_cell #(.K(SIN_DIV[i]), .SIDE_W(32)) u_cell (
         .clock  (clock),
         .en     (en),
         .x2_i   (sin_x2[i]),
         .t_i    (sin_t[i]),
         .side_i (sin_x[i]),
         .x2_o   (sin_x2[i+1]),
         .t_o    (sin_t[i+1]),
         .side_o (sin_x[i+1])
      );
   end

   for (genvar i = 0; i < 6; i++) begin : g_cos
      fk_horner_cell #(.K(COS_DIV[i]), .SIDE_W(3)) u_cell (
         .clock  (clock),
         .en     (en),
         .x2_i   (cos_x2[i]),
         .t_i    (cos_t[i]),
         .side_i (cos_oct[i]),
         .x2_o   (cos_x2[i+1]),
         .t_o    (cos_t[i+1]),
         .side_o (cos_oct[i+1])
      );
   end

   // The sine series is one step shorter; its final product and two delays line it up.
   logic [64:0] sxp;
   logic [32:0] sx_ff, sx_d1_ff, sx_d2_ff;

   assign sxp = 65'(sin_x[5]) * 65'(sin_t[5]);

   always_ff @(posedge clock) begin
      if (en) begin
         sx_ff <= sxp[64:32];
         sx_d1_ff <= sx_ff;
         sx_d2_ff <= sx_d1_ff;
      end
   end

   logic [33:0]         fs_sum, fc_sum;
   logic signed [W-1:0] fs, fc;
   logic signed [W-1:0] sin_ff, sin_in, cos_ff, cos_in;

   always_comb begin
      fs_sum = 34'(sx_d2_ff) + HALF_Q;
      fc_sum = 34'(cos_t[6]) + HALF_Q;
      fs = W'(fs_sum >> (32 - F));
      fc = W'(fc_sum >> (32 - F));
      case (cos_oct[6])
         3'd0: begin sin_in = fs; cos_in = fc; end
         3'd1: begin sin_in = fc; cos_in = fs; end
         3'd2: begin sin_in = fc; cos_in = -fs; end
         3'd3: begin sin_in = fs; cos_in = -fc; end
         3'd4: begin sin_in = -fs; cos_in = -fc; end
         3'd5: begin sin_in = -fc; cos_in = -fs; end
         3'd6: begin sin_in = -fc; cos_in = fs; end
         default: begin sin_in = -fs; cos_in = fc; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_o = sin_ff;
   assign cos_o = cos_ff;

endmodule

// ===== rtl/fk_joint_cell.sv =====
`timescale 1ns / 1ps
module fk_joint_cell #(
   parameter int ROT_FRAC_BITS = 14,
   parameter int RA = 0,
   parameter int RB = 2
) (
   input  logic                                    clock,
   input  logic                                    en,
   input  logic signed [ROT_FRAC_BITS+1:0]         sin_i,
   input  logic signed [ROT_FRAC_BITS+1:0]         cos_i,
   input  logic signed [fk_pkg::POS_W-1:0]         qa_i,
   input  logic signed [fk_pkg::POS_W-1:0]         qb_i,
   input  logic [8:0][ROT_FRAC_BITS+1:0]           rot_i,
   input  logic [2:0][fk_pkg::POS_W-1:0]           pos_i,
   output logic [8:0][ROT_FRAC_BITS+1:0]           rot_o,
   output logic [2:0][fk_pkg::POS_W-1:0]           pos_o
);
   import fk_pkg::*;

   localparam int F = ROT_FRAC_BITS;
   localparam int W = F + 2;
   localparam int RP = 2 * W;
   localparam int PP = W + POS_W + 1;
   localparam logic signed [RP:0] HALF_R = (RP+1)'(64'sd1 <<< (F - 1));
   localparam logic signed [RP:0] ONE_R = (RP+1)'(64'sd1 <<< F);
   localparam logic signed [PP:0] HALF_P = (PP+1)'(64'sd1 <<< (F - 1));

   function automatic logic signed [W-1:0] round_clamp(input logic signed [RP:0] v);
      logic signed [RP:0] sh;
      sh = (v + HALF_R) >>> F;
      if (sh > ONE_R) begin
         sh = ONE_R;
      end else if (sh < -ONE_R) begin
         sh = -ONE_R;
      end
      return W'(sh);
   endfunction

   function automatic logic [POS_W-1:0] round_pos(input logic signed [PP:0] v,
                                                   input logic signed [POS_W-1:0] q);
      logic signed [PP:0] sh;
      sh = ((v + HALF_P) >>> F) + (PP+1)'(q);
      return POS_W'(sh);
   endfunction

   logic signed [RP-1:0]      rca_ff [3], rsb_ff [3], rsa_ff [3], rcb_ff [3];
   logic signed [RP-1:0]      rca_in [3], rsb_in [3], rsa_in [3], rcb_in [3];
   logic signed [PP-1:0]      pca_ff, psb_ff, psa_ff, pcb_ff;
   logic signed [PP-1:0]      pca_in, psb_in, psa_in, pcb_in;
   logic signed [W-1:0]       ra_v, rb_v;
   logic signed [POS_W:0]     pa, pb;
   logic [8:0][W-1:0]         rot_1_ff, rot_2_ff, rot_2_in;
   logic [2:0][POS_W-1:0]     pos_1_ff, pos_2_ff, pos_2_in;

   // First stage: the products of the plane rotation; position is taken about the axis.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ra_v = $signed(rot_i[RA*3+k]);
         rb_v = $signed(rot_i[RB*3+k]);
         rca_in[k] = RP'(cos_i) * RP'(ra_v);
         rsb_in[k] = RP'(sin_i) * RP'(rb_v);
         rsa_in[k] = RP'(sin_i) * RP'(ra_v);
         rcb_in[k] = RP'(cos_i) * RP'(rb_v);
      end
      pa = (POS_W+1)'($signed(pos_i[RA])) - (POS_W+1)'(qa_i);
      pb = (POS_W+1)'($signed(pos_i[RB])) - (POS_W+1)'(qb_i);
      pca_in = PP'(cos_i) * PP'(pa);
      psb_in = PP'(sin_i) * PP'(pb);
      psa_in = PP'(sin_i) * PP'(pa);
      pcb_in = PP'(cos_i) * PP'(pb);
   end

   // Second stage: sums and rounding of rotation and position, clamp of the rotation entries.
   always_comb begin
      rot_2_in = rot_1_ff;
      pos_2_in = pos_1_ff;
      for (int k = 0; k < 3; k++) begin
         rot_2_in[RA*3+k] = round_clamp((RP+1)'(rca_ff[k]) - (RP+1)'(rsb_ff[k]));
         rot_2_in[RB*3+k] = round_clamp((RP+1)'(rsa_ff[k]) + (RP+1)'(rcb_ff[k]));
      end
      pos_2_in[RA] = round_pos((PP+1)'(pca_ff) - (PP+1)'(psb_ff), qa_i);
      pos_2_in[RB] = round_pos((PP+1)'(psa_ff) + (PP+1)'(pcb_ff), qb_i);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rca_ff <= rca_in;
         rsb_ff <= rsb_in;
         rsa_ff <= rsa_in;
         rcb_ff <= rcb_in;
         pca_ff <= pca_in;
         psb_ff <= psb_in;
         psa_ff <= psa_in;
         pcb_ff <= pcb_in;
         rot_1_ff <= rot_i;
         pos_1_ff <= pos_i;
         rot_2_ff <= rot_2_in;
         pos_2_ff <= pos_2_in;
      end
   end

   assign rot_o = rot_2_ff;
   assign pos_o = pos_2_ff;

endmodule

// ===== rtl/six_joint_forward_kinematics_unit.sv =====
`timescale 1ns / 1ps
// Forward kinematics of a six-joint revolute arm, product of exponentials.
// req_if carries six joint angles per transaction; rsp_if returns the 3x3 tool
// rotation (Q2.14 by default) and the saturated tool position in the units of the
// link lengths. csr_if writes the six link lengths by index; it is always ready
// and is to be written only while no transaction is in flight.
// The datapath is a pipeline of cells: per angle a sine/cosine unit built from
// three-stage Horner cells, then six rotation cells of two stages each.
// One transaction is taken every cycle while req_if is ready.
// When the receiver stalls, the result stays in the output register; the pipeline
// keeps moving until a finished result reaches its end, and only then does req_if
// drop ready. Reset empties the pipeline and clears all link lengths to zero.
module six_joint_forward_kinematics_unit #(
   parameter int ANGLE_BITS = 16,
   parameter int ROT_FRAC_BITS = 14
) (
   input logic   clock,
   input logic   reset,
   fk_req_if.sink   req_if,
   fk_rsp_if.source rsp_if,
   fk_csr_if.sink   csr_if
);
   import fk_pkg::*;

   localparam int F = ROT_FRAC_BITS;
   localparam int W = F + 2;
   localparam int LAT = 33;
   localparam logic signed [W-1:0] ONE = W'(64'sd1 <<< F);
   localparam int JRA [6] = '{1, 0, 1, 0, 0, 0};
   localparam int JRB [6] = '{2, 2, 2, 2, 2, 1};

   // Link length registers.
   logic [LEN_W-1:0] r1_ff, r2_ff, r3_ff, d1_ff, d4_ff, d6_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_ff <= '0;
         r2_ff <= '0;
         r3_ff <= '0;
         d1_ff <= '0;
         d4_ff <= '0;
         d6_ff <= '0;
      end else if (csr_if.valid) begin
         unique case (csr_index_type'(csr_if.index))
            CSR_BASE_TO_SHOULDER: r1_ff <= csr_if.data;
            CSR_UPPER_ARM:        r2_ff <= csr_if.data;
            CSR_FOREARM_HEIGHT:   r3_ff <= csr_if.data;
            CSR_BASE_HEIGHT:      d1_ff <= csr_if.data;
            CSR_WRIST_OFFSET:     d4_ff <= csr_if.data;
            CSR_TOOL_OFFSET:      d6_ff <= csr_if.data;
            default: ;
         endcase
      end
   end

   logic signed [POS_W-1:0] q_r1, q_r1d4, q_d1, q_d1r2, q_top, home_x, q_zero;

   always_comb begin
      q_zero = '0;
      q_r1 = POS_W'(r1_ff);
      q_r1d4 = POS_W'(r1_ff) + POS_W'(d4_ff);
      q_d1 = POS_W'(d1_ff);
      q_d1r2 = POS_W'(d1_ff) + POS_W'(r2_ff);
      q_top = q_d1r2 + POS_W'(r3_ff);
      home_x = q_r1d4 + POS_W'(d6_ff);
   end

   // Pipeline control.
   logic [LAT-1:0] vld_ff;
   logic           adv;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           load;

   assign adv = !(rsp_valid_ff && !rsp_if.ready && vld_ff[LAT-1]);
   assign load = adv && vld_ff[LAT-1];
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_if.ready);
   assign req_if.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            vld_ff <= {vld_ff[LAT-2:0], req_if.valid};
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Joint chain: the last joint is applied first to the home pose.
   logic [ANGLE_W-1:0]    ang_sel [6];
   logic signed [POS_W-1:0] qa_sel [6], qb_sel [6];
   logic [8:0][W-1:0]     jrot [7];
   logic [2:0][POS_W-1:0] jpos [7];

   always_comb begin
      ang_sel = '{req_if.angle_six, req_if.angle_five, req_if.angle_four,
                  req_if.angle_three, req_if.angle_two, req_if.angle_one};
      qa_sel = '{q_zero, q_r1d4, q_zero, q_r1, q_r1, q_zero};
      qb_sel = '{q_top, q_top, q_top, q_d1r2, q_d1, q_zero};
      jrot[0] = '0;
      jrot[0][2] = ONE;
      jrot[0][3] = ONE;
      jrot[0][7] = ONE;
      jpos[0][0] = home_x;
      jpos[0][1] = q_zero;
      jpos[0][2] = q_top;
   end

   for (genvar p = 0; p < 6; p++) begin : g_joint
      logic [ANGLE_W-1:0]  ang_d;
      logic signed [W-1:0] s_w, c_w;

      // Each angle passes through two delay registers per joint ahead of it in the chain.
      if (p == 0) begin : g_direct
         assign ang_d = ang_sel[p];
      end else begin : g_delay
         logic [ANGLE_W-1:0] dly_ff [2*p];
         always_ff @(posedge clock) begin
            if (adv) begin
               dly_ff[0] <= ang_sel[p];
               for (int i = 1; i < 2 * p; i++) begin
                  dly_ff[i] <= dly_ff[i-1];
               end
            end
         end
         assign ang_d = dly_ff[2*p-1];
      end

      fk_sincos #(.ANGLE_BITS(ANGLE_BITS), .ROT_FRAC_BITS(F)) u_sincos (
         .clock   (clock),
         .en      (adv),
         .angle_i (ang_d),
         .sin_o   (s_w),
         .cos_o   (c_w)
      );

      fk_joint_cell #(.ROT_FRAC_BITS(F), .RA(JRA[p]), .RB(JRB[p])) u_joint (
         .clock (clock),
         .en    (adv),
         .sin_i (s_w),
         .cos_i (c_w),
         .qa_i  (qa_sel[p]),
         .qb_i  (qb_sel[p]),
         .rot_i (jrot[p]),
         .pos_i (jpos[p]),
         .rot_o (jrot[p+1]),
         .pos_o (jpos[p+1])
      );
   end

   // Output register.
   logic [ROT_OUT_W-1:0] rot_out_ff [9], rot_out_in [9];
   logic [POS_OUT_W-1:0] pos_out_ff [3], pos_out_in [3];
   logic signed [63:0]   pos_wide;
   logic                 rot_ok;

   always_comb begin
      rot_ok = 1'b1;
      for (int i = 0; i < 9; i++) begin
         rot_out_in[i] = ROT_OUT_W'(64'($signed(jrot[6][i])));
         if ($signed(jrot[6][i]) > ONE || $signed(jrot[6][i]) < -ONE) begin
            rot_ok = 1'b0;
         end
      end
      for (int i = 0; i < 3; i++) begin
         pos_wide = 64'($signed(jpos[6][i]));
         if (pos_wide > POS_SAT_MAX) begin
            pos_wide = POS_SAT_MAX;
         end else if (pos_wide < POS_SAT_MIN) begin
            pos_wide = POS_SAT_MIN;
         end
         pos_out_in[i] = POS_OUT_W'(pos_wide);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rot_out_ff <= rot_out_in;
         pos_out_ff <= pos_out_in;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.rot_xx = rot_out_ff[0];
   assign rsp_if.rot_xy = rot_out_ff[1];
   assign rsp_if.rot_xz = rot_out_ff[2];
   assign rsp_if.rot_yx = rot_out_ff[3];
   assign rsp_if.rot_yy = rot_out_ff[4];
   assign rsp_if.rot_yz = rot_out_ff[5];
   assign rsp_if.rot_zx = rot_out_ff[6];
   assign rsp_if.rot_zy = rot_out_ff[7];
   assign rsp_if.rot_zz = rot_out_ff[8];
   assign rsp_if.pos_x = pos_out_ff[0];
   assign rsp_if.pos_y = pos_out_ff[1];
   assign rsp_if.pos_z = pos_out_ff[2];

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> vld_ff[0])
      else $error("accepted transaction did not enter the pipeline");

   a_rsp_from_pipe: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(vld_ff[LAT-1]))
      else $error("response raised without a finished transaction");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_if.ready && vld_ff[LAT-1]) |=> $stable(vld_ff))
      else $error("pipeline moved while its last stage was blocked");

   a_rot_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAT-1] |-> rot_ok)
      else $error("rotation entry outside the unit range");

endmodule
